// ===== hdl/masked_pixel_to_rgb888_top_defines.svh =====
// Assertion helpers shared by the block's RTL.
`ifndef MASKED_PIXEL_TO_RGB888_TOP_DEFINES_SVH
`define MASKED_PIXEL_TO_RGB888_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MP2R_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MP2R_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mp2r_pkg.sv =====
package mp2r_pkg;

    localparam int MAP_DEPTH_DEF  = 256;
    localparam int PIXEL_BITS_DEF = 32;
    localparam int ADDR_W         = 4;
    localparam int DIV_STEPS      = 8;

    typedef enum logic [1:0] {
        REG_RED   = 2'd0,
        REG_GREEN = 2'd1,
        REG_BLUE  = 2'd2,
        REG_COUNT = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_MAP = 2'd1,
        ST_BEYOND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CH_ZERO = 2'd0,
        CH_MAP  = 2'd1,
        CH_DIV  = 2'd2
    } chan_sel_t;

    // One channel in flight through the divider
    typedef struct packed {
        logic [47:0] rem;
        logic [39:0] den;
        logic [7:0]  quo;
        chan_sel_t   sel;
        logic [7:0]  map_byte;
    } chan_t;

    typedef struct packed {
        chan_t [2:0] ch;
        logic [7:0]  pal_idx;
        logic        is_pal;
        status_t     status;
    } div_item_t;

    // Count trailing zeros; zero input gives zero
    function automatic logic [4:0] tz32(input logic [31:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/mp2r_ram.sv =====
module mp2r_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/masked_pixel_to_rgb888_top.sv =====
// Packed pixel to RGB888 converter. Takes one item per clock while in_ready is
// high and returns one result per pixel item; a colormap write (mode 1) returns
// nothing. A result passes through stage 1, the divider stages and the output
// register; the eight-step restoring divider pipeline scales direct-color
// fields, and colormap lookups travel alongside in step.
// The colormap lives in three synchronous memories, one per channel, so all
// three channel lookups happen in the cycle after acceptance. The colormap
// has no reset: write an entry before any pixel indexes it. The user must write
// masks and map_count over the APB port only while the block is idle; the block itself does not enforce this.
`include "masked_pixel_to_rgb888_top_defines.svh"

module masked_pixel_to_rgb888_top #(
    parameter int MAP_DEPTH  = mp2r_pkg::MAP_DEPTH_DEF,
    parameter int PIXEL_BITS = mp2r_pkg::PIXEL_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mp2r_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        mode,
    input  logic [31:0]                 pixel_word,
    input  logic [7:0]                  entry_slot,
    input  logic [15:0]                 entry_red,
    input  logic [15:0]                 entry_green,
    input  logic [15:0]                 entry_blue,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  red_byte,
    output logic [7:0]                  green_byte,
    output logic [7:0]                  blue_byte,
    output logic [7:0]                  palette_index,
    output logic                        is_palette,
    output logic [1:0]                  status
);

    import mp2r_pkg::*;

    localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam logic [31:0] PMASK = 32'((64'd1 << PIXEL_BITS) - 64'd1);

    // Configuration registers and derived shift and field masks
    logic [31:0] mask_reg  [3];
    logic [4:0]  shift_reg [3];
    logic [31:0] fmask_reg [3];
    logic [8:0]  map_count_reg;

    logic        cfg_wr;
    reg_idx_t    cfg_idx;
    logic [31:0] w_mask;
    logic [4:0]  w_shift;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign w_mask  = pwdata & PMASK;
    assign w_shift = tz32(w_mask);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                mask_reg[c]  <= '0;
                shift_reg[c] <= '0;
                fmask_reg[c] <= '0;
            end
            map_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_RED, REG_GREEN, REG_BLUE:
                begin
                    mask_reg[cfg_idx]  <= pwdata;
                    shift_reg[cfg_idx] <= w_shift;
                    fmask_reg[cfg_idx] <= w_mask >> w_shift;
                end
                REG_COUNT: map_count_reg <= pwdata[8:0];
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (cfg_idx)
            REG_RED, REG_GREEN, REG_BLUE: prdata = mask_reg[cfg_idx];
            REG_COUNT:                    prdata = {23'b0, map_count_reg};
        endcase
    end

    // Pipeline control
    logic                 s1_v_reg;
    logic [DIV_STEPS-1:0] stg_v_reg;
    logic                 out_v_reg;
    logic                 en_s1;
    logic [DIV_STEPS-1:0] en_stg;
    logic                 en_out;
    logic                 acc;

    always_comb
    begin
        en_out = !out_v_reg | out_ready;
        en_stg[DIV_STEPS-1] = !stg_v_reg[DIV_STEPS-1] | en_out;
        for (int j = DIV_STEPS - 2; j >= 0; j--)
        begin
            en_stg[j] = !stg_v_reg[j] | en_stg[j+1];
        end
        en_s1 = !s1_v_reg | en_stg[0];
    end

    assign in_ready = en_s1;
    assign acc      = in_valid & en_s1;

    // Field extraction at acceptance
    logic [8:0]  live_cnt;
    logic        map_on;
    logic [31:0] pix;
    logic [31:0] fld [3];
    logic [2:0]  bad;
    chan_sel_t   sel [3];
    logic        any_mask;
    logic [7:0]  pal_idx;
    status_t     st;

    always_comb
    begin
        live_cnt = (map_count_reg > 9'(MAP_DEPTH)) ? 9'd0 : map_count_reg;
        map_on   = (live_cnt != 9'd0);
        pix      = pixel_word & PMASK;
        any_mask = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            fld[c]   = (pix >> shift_reg[c]) & fmask_reg[c];
            any_mask = any_mask | (fmask_reg[c] != 32'd0);
            bad[c]   = map_on && (fmask_reg[c] != 32'd0) && (fld[c] >= {23'b0, live_cnt});
            // zero the channel for an empty mask or an index beyond the map
            if (fmask_reg[c] == 32'd0 || bad[c])
                sel[c] = CH_ZERO;
            else if (map_on)
                sel[c] = CH_MAP;
            else
                sel[c] = CH_DIV;
        end
        if (any_mask)
        begin
            pal_idx = 8'd0;
            st      = (|bad) ? ST_BEYOND : ST_OK;
        end
        else if (!map_on)
        begin
            pal_idx = 8'd0;
            st      = ST_NO_MAP;
        end
        else
        begin
            pal_idx = pix[7:0];
            st      = ({1'b0, pix[7:0]} >= live_cnt) ? ST_BEYOND : ST_OK;
        end
    end

    // Colormap memories, one per channel
    logic [15:0] entry_d [3];
    logic [15:0] ram_q   [3];
    logic        map_we;
    logic        map_re;

    assign entry_d[0] = entry_red;
    assign entry_d[1] = entry_green;
    assign entry_d[2] = entry_blue;
    assign map_we = acc & mode & ({1'b0, entry_slot} < 9'(MAP_DEPTH));
    assign map_re = acc & !mode;

    for (genvar c = 0; c < 3; c++)
    begin : g_map
        mp2r_ram #(
            .WIDTH (16),
            .DEPTH (MAP_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (map_we),
            .waddr (AW'(entry_slot)),
            .wdata (entry_d[c]),
            .re    (map_re),
            .raddr (fld[c][AW-1:0]),
            .rdata (ram_q[c])
        );
    end

    // Stage 1: fields wait for memory data
    logic [31:0] s1_f_reg   [3];
    logic [31:0] s1_m_reg   [3];
    chan_sel_t   s1_sel_reg [3];
    logic [7:0]  s1_pidx_reg;
    logic        s1_pal_reg;
    status_t     s1_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en_s1)
        begin
            s1_v_reg <= in_valid & !mode;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_s1)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s1_f_reg[c]   <= fld[c];
                s1_m_reg[c]   <= fmask_reg[c];
                s1_sel_reg[c] <= sel[c];
            end
            s1_pidx_reg <= pal_idx;
            s1_pal_reg  <= !any_mask;
            s1_st_reg   <= st;
        end
    end

    // Build the divider input: field*65535 over mask*256
    div_item_t stg_in;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            stg_in.ch[c].rem      = {s1_f_reg[c], 16'b0} - {16'b0, s1_f_reg[c]};
            stg_in.ch[c].den      = {s1_m_reg[c], 8'b0};
            stg_in.ch[c].quo      = 8'd0;
            stg_in.ch[c].sel      = s1_sel_reg[c];
            stg_in.ch[c].map_byte = ram_q[c][15:8];
        end
        stg_in.pal_idx = s1_pidx_reg;
        stg_in.is_pal  = s1_pal_reg;
        stg_in.status  = s1_st_reg;
    end

    // Divider stages, one quotient bit each, high bit first
    div_item_t   stg_reg [DIV_STEPS];
    div_item_t   stg_res [DIV_STEPS];
    logic [47:0] trial;

    always_comb
    begin
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            stg_res[j] = stg_reg[j];
            for (int c = 0; c < 3; c++)
            begin
                trial = {8'b0, stg_reg[j].ch[c].den} << (DIV_STEPS - 1 - j);
                if (stg_reg[j].ch[c].rem >= trial)
                begin
                    stg_res[j].ch[c].rem = stg_reg[j].ch[c].rem - trial;
                    stg_res[j].ch[c].quo[DIV_STEPS-1-j] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_v_reg <= '0;
        end
        else
        begin
            if (en_stg[0])
            begin
                stg_v_reg[0] <= s1_v_reg;
            end
            for (int j = 1; j < DIV_STEPS; j++)
            begin
                if (en_stg[j])
                begin
                    stg_v_reg[j] <= stg_v_reg[j-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_stg[0])
        begin
            stg_reg[0] <= stg_in;
        end
        for (int j = 1; j < DIV_STEPS; j++)
        begin
            if (en_stg[j])
            begin
                stg_reg[j] <= stg_res[j-1];
            end
        end
    end

    // Output register: pick each channel's byte
    logic [7:0] byte_sel [3];
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] pidx_reg;
    logic       pal_reg;
    status_t    st_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            case (stg_res[DIV_STEPS-1].ch[c].sel)
                CH_MAP:  byte_sel[c] = stg_res[DIV_STEPS-1].ch[c].map_byte;
                CH_DIV:  byte_sel[c] = stg_res[DIV_STEPS-1].ch[c].quo;
                default: byte_sel[c] = 8'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_v_reg <= stg_v_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            red_reg   <= byte_sel[0];
            green_reg <= byte_sel[1];
            blue_reg  <= byte_sel[2];
            pidx_reg  <= stg_res[DIV_STEPS-1].pal_idx;
            pal_reg   <= stg_res[DIV_STEPS-1].is_pal;
            st_reg    <= stg_res[DIV_STEPS-1].status;
        end
    end

    assign out_valid     = out_v_reg;
    assign red_byte      = red_reg;
    assign green_byte    = green_reg;
    assign blue_byte     = blue_reg;
    assign palette_index = pidx_reg;
    assign is_palette    = pal_reg;
    assign status        = st_reg;

    // Checks
    `MP2R_ASSERT_NEXT(a_pix_enters, clk, rst_n, in_valid && in_ready && !mode, s1_v_reg,
        "accepted pixel item did not enter stage 1")
    `MP2R_ASSERT_NOW(a_stall_blocks, clk, rst_n, s1_v_reg && !en_stg[0], !in_ready,
        "input accepted while stage 1 is stalled")
    `MP2R_ASSERT_NOW(a_pal_rgb_zero, clk, rst_n, out_v_reg && pal_reg,
        (red_reg == 8'd0) && (green_reg == 8'd0) && (blue_reg == 8'd0),
        "palette result carries nonzero RGB")
    `MP2R_ASSERT_NOW(a_nomap_pal, clk, rst_n, out_v_reg && (st_reg == ST_NO_MAP),
        pal_reg && (pidx_reg == 8'd0), "missing-map status on a non-palette result")

endmodule
